### rtl/fed_pkg.sv
`timescale 1ns / 1ps

package fed_pkg;

   localparam int RING_FRAMES_DEF = 65536;
   localparam int CHANNELS_DEF    = 2;

   localparam int SAMPLE_W   = 16;
   localparam int MIX_W      = 16;
   localparam int DELAY_W    = 16;
   localparam int FB_W       = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [MIX_W-1:0] MIX_ONE    = 16'd32768;
   localparam logic [MIX_W-1:0] MIX_BYPASS = 16'd32;
   localparam logic [FB_W-1:0]  FB_CAP     = 15'd27852;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WET_MIX       = 2'd0,
      CSR_DELAY_FRAMES  = 2'd1,
      CSR_FEEDBACK_GAIN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic bypass;
   } fed_ctl_type;

   typedef struct packed {
      logic [MIX_W-1:0] mix;
      logic [MIX_W-1:0] inv_mix;
      logic [FB_W-1:0]  fb;
      logic             bypass;
   } fed_coef_type;

endpackage

### rtl/feedback_echo_delay_top.sv
`timescale 1ns / 1ps
// feedback echo delay line for Q1.15 audio
// request channel: req_tdata carries the dry sample, req_tuser the channel
// and req_tlast marks the last sample of a frame, which advances the ring's
// write frame. response channel: rsp_tdata carries the mixed sample, one per
// request, in request order.
// configuration: csr_we writes csr_wdata into register csr_index
// (0 wet mix, 1 delay in frames, 2 feedback gain); the user must do so only
// while the block is idle, as the block does not enforce it. a wet mix of
// 32 or less passes samples through and holds the ring. throughput: one
// request per cycle while req_tready is high; the ring memory is read at
// accept and written from stage s2, with forwarding from the pending writes.
// reset: the ring is zeroed one entry per cycle, all RING_FRAMES * CHANNELS
// entries (131072 by default); req_tready stays low until that pass ends.
// configuration writes are taken during the pass.
// stall: when rsp_tready is low with a response waiting, the whole pipeline
// holds and req_tready drops; nothing is lost or repeated.
module feedback_echo_delay_top
   import fed_pkg::*;
#(
   parameter int RING_FRAMES = RING_FRAMES_DEF,
   parameter int CHANNELS    = CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // sample_in
   input  logic [0:0]            req_tuser,   // channel
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,   // sample_out
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = RING_FRAMES * CHANNELS;
   localparam int AW    = $clog2(DEPTH);

   logic [MIX_W-1:0]    wet_mix_ff;
   logic [DELAY_W-1:0]  delay_ff;
   logic [FB_W-1:0]     fb_ff;
   fed_coef_type        coef;
   logic                advance;

   logic                ram_re, clr_we, wr_en, ram_we;
   logic [AW-1:0]       ram_raddr, clr_addr, wr_addr, ram_waddr;
   logic [SAMPLE_W-1:0] wr_data, ram_wdata, ram_rdata;
   fed_ctl_type         s1_ctl;
   logic [AW-1:0]       s1_waddr, s1_raddr;
   logic [SAMPLE_W-1:0] s1_dry;

   always_ff @(posedge clock) begin
      if (reset) begin
         wet_mix_ff <= '0;
         delay_ff   <= DELAY_W'(1);
         fb_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WET_MIX:       wet_mix_ff <= csr_wdata[MIX_W-1:0];
            CSR_DELAY_FRAMES:  delay_ff   <= csr_wdata[DELAY_W-1:0];
            CSR_FEEDBACK_GAIN: fb_ff      <= csr_wdata[FB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      coef.bypass  = (wet_mix_ff <= MIX_BYPASS);
      coef.mix     = (wet_mix_ff > MIX_ONE) ? MIX_ONE : wet_mix_ff;
      coef.inv_mix = MIX_ONE - coef.mix;
      coef.fb      = (fb_ff > FB_CAP) ? FB_CAP : fb_ff;
   end

   assign advance = !rsp_tvalid || rsp_tready;

   fed_addr #(
      .RING_FRAMES (RING_FRAMES),
      .CHANNELS    (CHANNELS)
   ) u_addr (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_sample   (req_tdata),
      .req_channel  (req_tuser[0]),
      .req_eof      (req_tlast),
      .delay_frames (delay_ff),
      .bypass       (coef.bypass),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .clr_we       (clr_we),
      .clr_addr     (clr_addr),
      .s1_ctl       (s1_ctl),
      .s1_waddr     (s1_waddr),
      .s1_raddr     (s1_raddr),
      .s1_dry       (s1_dry)
   );

   fed_mix #(
      .AW (AW)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .s1_ctl    (s1_ctl),
      .s1_waddr  (s1_waddr),
      .s1_raddr  (s1_raddr),
      .s1_dry    (s1_dry),
      .ram_rdata (ram_rdata),
      .coef      (coef),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_tdata)
   );

   assign ram_we    = clr_we || wr_en;
   assign ram_waddr = clr_we ? clr_addr : wr_addr;
   assign ram_wdata = clr_we ? '0 : wr_data;

   fed_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

### rtl/fed_ram.sv
`timescale 1ns / 1ps

module fed_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/fed_addr.sv
`timescale 1ns / 1ps

module fed_addr
   import fed_pkg::*;
#(
   parameter int RING_FRAMES = RING_FRAMES_DEF,
   parameter int CHANNELS    = CHANNELS_DEF,
   localparam int DEPTH      = RING_FRAMES * CHANNELS,
   localparam int AW         = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_channel,
   input  logic                req_eof,
   input  logic [DELAY_W-1:0]  delay_frames,
   input  logic                bypass,
   output logic                ram_re,
   output logic [AW-1:0]       ram_raddr,
   output logic                clr_we,
   output logic [AW-1:0]       clr_addr,
   output fed_ctl_type         s1_ctl,
   output logic [AW-1:0]       s1_waddr,
   output logic [AW-1:0]       s1_raddr,
   output logic [SAMPLE_W-1:0] s1_dry
);

   localparam int FW = $clog2(RING_FRAMES);
   localparam int SW = ((FW > DELAY_W) ? FW : DELAY_W) + 1;
   localparam logic [SW-1:0] RING_S = SW'(RING_FRAMES);
   localparam logic [SW-1:0] MAX_D  = SW'(RING_FRAMES - 1);

   logic [FW-1:0]     wf_ff, wf_in, wf_inc, rf;
   logic [SW-1:0]     d, wf_s, rf_s;
   logic              ch, accept;
   logic [AW-1:0]     waddr, raddr;
   logic              clr_busy_ff, clr_busy_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   fed_ctl_type       s1_ctl_ff;
   logic [AW-1:0]     s1_waddr_ff, s1_raddr_ff;
   logic [SAMPLE_W-1:0] s1_dry_ff;

   always_comb begin
      d = SW'(delay_frames);
      if (d == '0) begin
         d = SW'(1);
      end
      if (d > MAX_D) begin
         d = MAX_D;
      end
      wf_s   = SW'(wf_ff);
      rf_s   = (wf_s >= d) ? (wf_s - d) : (wf_s + RING_S - d);
      rf     = rf_s[FW-1:0];
      wf_inc = (wf_ff == FW'(RING_FRAMES - 1)) ? '0 : wf_ff + 1'b1;
      ch     = (CHANNELS == 1) ? 1'b0 : req_channel;
      waddr  = AW'(wf_ff) * AW'(CHANNELS) + AW'(ch);
      raddr  = AW'(rf) * AW'(CHANNELS) + AW'(ch);
   end

   assign req_ready = !clr_busy_ff && advance;
   assign accept    = req_valid && req_ready;
   assign wf_in     = (accept && req_eof && !bypass) ? wf_inc : wf_ff;

   // zero the ring one entry per cycle after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wf_ff       <= '0;
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         s1_ctl_ff   <= '0;
      end else begin
         wf_ff       <= wf_in;
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
         if (advance) begin
            s1_ctl_ff.valid  <= accept;
            s1_ctl_ff.bypass <= bypass;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_waddr_ff <= waddr;
         s1_raddr_ff <= raddr;
         s1_dry_ff   <= req_sample;
      end
   end

   assign ram_re    = accept;
   assign ram_raddr = raddr;
   assign clr_we    = clr_busy_ff;
   assign clr_addr  = clr_cnt_ff;
   assign s1_ctl    = s1_ctl_ff;
   assign s1_waddr  = s1_waddr_ff;
   assign s1_raddr  = s1_raddr_ff;
   assign s1_dry    = s1_dry_ff;

endmodule

### rtl/fed_mix.sv
`timescale 1ns / 1ps

module fed_mix
   import fed_pkg::*;
#(
   parameter int AW = 17
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  fed_ctl_type         s1_ctl,
   input  logic [AW-1:0]       s1_waddr,
   input  logic [AW-1:0]       s1_raddr,
   input  logic [SAMPLE_W-1:0] s1_dry,
   input  logic [SAMPLE_W-1:0] ram_rdata,
   input  fed_coef_type        coef,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output logic [SAMPLE_W-1:0] wr_data,
   output logic                rsp_valid,
   output logic [SAMPLE_W-1:0] rsp_data
);

   function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [17:0] v);
      logic [SAMPLE_W-1:0] r;
      if (v > 18'sd32767) begin
         r = 16'h7fff;
      end else if (v < -18'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   logic                       fwd_s2, fwd_pw;
   logic signed [15:0]         delayed, dry1;
   logic signed [15:0]         fb_op;
   logic signed [16:0]         mix_op, inv_op;
   logic signed [31:0]         fb_prod;
   logic signed [32:0]         wet_prod, dry_prod;

   fed_ctl_type                s2_ctl_ff;
   logic [AW-1:0]              s2_waddr_ff;
   logic signed [15:0]         s2_dry_ff;
   logic signed [31:0]         s2_fb_ff;
   logic signed [32:0]         s2_wet_ff, s2_drp_ff;

   logic                       pw_valid_ff;
   logic [AW-1:0]              pw_addr_ff;
   logic [SAMPLE_W-1:0]        pw_data_ff;

   logic signed [17:0]         wr_sum, out_sum;
   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        rsp_data_ff;

   // forward writes the read could not see
   assign fwd_s2 = s2_ctl_ff.valid && !s2_ctl_ff.bypass && (s2_waddr_ff == s1_raddr);
   assign fwd_pw = pw_valid_ff && (pw_addr_ff == s1_raddr);

   always_comb begin
      if (fwd_s2) begin
         delayed = wr_data;
      end else if (fwd_pw) begin
         delayed = pw_data_ff;
      end else begin
         delayed = ram_rdata;
      end
      dry1     = s1_dry;
      fb_op    = {1'b0, coef.fb};
      mix_op   = {1'b0, coef.mix};
      inv_op   = {1'b0, coef.inv_mix};
      fb_prod  = fb_op * delayed;
      wet_prod = mix_op * delayed;
      dry_prod = inv_op * dry1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         pw_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            s2_ctl_ff    <= s1_ctl;
            rsp_valid_ff <= s2_ctl_ff.valid;
         end
         if (wr_en) begin
            pw_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_waddr_ff <= s1_waddr;
         s2_dry_ff   <= dry1;
         s2_fb_ff    <= fb_prod;
         s2_wet_ff   <= wet_prod;
         s2_drp_ff   <= dry_prod;
         rsp_data_ff <= s2_ctl_ff.bypass ? s2_dry_ff : sat16(out_sum);
      end
      if (wr_en) begin
         pw_addr_ff <= wr_addr;
         pw_data_ff <= wr_data;
      end
   end

   // floor shift by 15 is the upper slice of each product
   assign wr_sum  = {{2{s2_dry_ff[15]}}, s2_dry_ff} + {s2_fb_ff[31], s2_fb_ff[31:15]};
   assign out_sum = s2_drp_ff[32:15] + s2_wet_ff[32:15];

   assign wr_en     = advance && s2_ctl_ff.valid && !s2_ctl_ff.bypass;
   assign wr_addr   = s2_waddr_ff;
   assign wr_data   = sat16(wr_sum);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
